/* design/pnmp_pkg.sv */
// shared constants, types and helpers for the neighbor-mean pixel predictor
`default_nettype none

package pnmp_pkg;

    // line store geometry
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;

    // register field widths
    localparam int PIX_W    = 8;
    localparam int IMG_W_W  = 12;
    localparam int IMG_H_W  = 16;
    localparam int CFG_D_W  = 16;
    localparam int CFG_I_W  = 2;

    // width used to compare column counts against the row width
    localparam int CMP_W = ((COL_W > IMG_W_W) ? COL_W : IMG_W_W) + 1;

    // register reset values
    localparam logic [IMG_W_W-1:0] IMG_W_RESET = IMG_W_W'(640);
    localparam logic [IMG_H_W-1:0] IMG_H_RESET = IMG_H_W'(480);

    // register indexes
    typedef enum logic [CFG_I_W-1:0] {
        CFG_RESTORE_MODE = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

    // floor(x / 3) for x up to three pixels summed, by reciprocal 683 / 2^11
    localparam int SUM_W    = PIX_W + 2;
    localparam int PROD_W   = 2 * SUM_W;
    localparam int RECIP3   = 683;
    localparam int RECIP_SH = 11;

    function automatic logic [PIX_W-1:0] div3(input logic [SUM_W-1:0] x);
        logic [PROD_W-1:0] p;
        p = PROD_W'(x) * PROD_W'(RECIP3);
        return p[RECIP_SH +: PIX_W];
    endfunction

endpackage

`default_nettype wire

/* design/pixel_neighbor_mean_predictor.sv */
// neighbor-mean pixel predictor: residual forming and pixel reconstruction
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------
//  s_      | in        | s_valid / s_ready     | s_pixel_in
//  m_      | out       | m_valid / m_ready     | m_pixel_out, m_frame_last
//  cfg_    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  one beat per clock in and out while the output is not stalled
//  the line store read is issued at input accept and registered, then the
//  prediction and result are formed in the work stage into the output register
//  a stalled output holds the work stage, and s_ready drops only then
//  aresetn clears counters, neighbor pixels and valids and resets registers; no clearing
//  pass, the line store is undefined until written; cfg_ready is always high
`default_nettype none

module pixel_neighbor_mean_predictor (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input pixel beats
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [pnmp_pkg::PIX_W-1:0]     s_pixel_in,
    // result beats
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [pnmp_pkg::PIX_W-1:0]          m_pixel_out,
    output logic                                m_frame_last,
    // register writes
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [pnmp_pkg::CFG_I_W-1:0]   cfg_index,
    input  wire logic [pnmp_pkg::CFG_D_W-1:0]   cfg_data
);

    localparam int PW = pnmp_pkg::PIX_W;
    localparam int CW = pnmp_pkg::COL_W;
    localparam int KW = pnmp_pkg::CMP_W;
    localparam int HW = pnmp_pkg::IMG_H_W;
    localparam int WW = pnmp_pkg::IMG_W_W;
    localparam int SW = pnmp_pkg::SUM_W;

    // configuration registers
    logic          restore_mode_reg;
    logic [WW-1:0] image_width_reg;
    logic [HW-1:0] image_height_reg;

    // position counters, advanced at input accept
    logic [CW-1:0] column_count_reg, column_count_next;
    logic [HW-1:0] row_count_reg,    row_count_next;

    // committed neighbor pixels, updated when the work stage retires
    logic [PW-1:0] left_pixel_reg;
    logic [PW-1:0] upleft_pixel_reg;

    // line store
    logic [PW-1:0] row_store [pnmp_pkg::MAX_WIDTH];
    logic [PW-1:0] rd_data_reg;
    logic          byp_reg;
    logic [PW-1:0] byp_data_reg;

    // work stage
    logic          s1_valid_reg;
    logic [PW-1:0] s1_pixel_reg;
    logic [CW-1:0] s1_slot_reg;
    logic          s1_col_zero_reg;
    logic          s1_row_zero_reg;
    logic          s1_last_reg;

    // output register
    logic          out_valid_reg;
    logic [PW-1:0] out_pixel_reg;
    logic          out_last_reg;

    logic          s_accept;
    logic          s1_adv;
    logic          s1_fire;

    logic [KW-1:0] eff_width;
    logic [HW-1:0] eff_height;
    logic          last_col;
    logic          last_row;

    logic [PW-1:0] up_pixel;
    logic [SW-1:0] numer;
    logic [PW-1:0] pred;
    logic [PW-1:0] res;
    logic [PW-1:0] store_val;

    // handshakes: the work stage moves on whenever the output register is free
    assign s1_adv   = !out_valid_reg || m_ready;
    assign s1_fire  = s1_valid_reg && s1_adv;
    assign s_ready  = !s1_valid_reg || s1_adv;
    assign s_accept = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // effective frame size: zero acts as one, width clipped to the line store
    always_comb begin
        eff_width = KW'(image_width_reg);
        if (eff_width == '0) begin
            eff_width = KW'(1);
        end
        if (eff_width > KW'(pnmp_pkg::MAX_WIDTH)) begin
            eff_width = KW'(pnmp_pkg::MAX_WIDTH);
        end
        eff_height = (image_height_reg == '0) ? HW'(1) : image_height_reg;
    end

    // a counter at or past the end counts as the last position
    assign last_col = KW'(column_count_reg) >= (eff_width - KW'(1));
    assign last_row = row_count_reg >= (eff_height - HW'(1));

    always_comb begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (s_accept) begin
            if (last_col) begin
                column_count_next = '0;
                row_count_next    = last_row ? '0 : (row_count_reg + HW'(1));
            end else begin
                column_count_next = column_count_reg + CW'(1);
            end
        end
    end

    // pixel above: forwarded when the retiring beat writes the slot being read
    assign up_pixel = byp_reg ? byp_data_reg : rd_data_reg;

    // prediction: first pixel zero, top row left/3, left column up/3, else mean of three
    always_comb begin
        if (s1_row_zero_reg) begin
            numer = s1_col_zero_reg ? '0 : SW'(left_pixel_reg);
        end else if (s1_col_zero_reg) begin
            numer = SW'(up_pixel);
        end else begin
            numer = SW'(left_pixel_reg) + SW'(upleft_pixel_reg) + SW'(up_pixel);
        end
        pred = pnmp_pkg::div3(numer);
        if (restore_mode_reg) begin
            res       = s1_pixel_reg + pred;
            store_val = res;
        end else begin
            res       = s1_pixel_reg - pred;
            store_val = s1_pixel_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            restore_mode_reg <= 1'b0;
            image_width_reg  <= pnmp_pkg::IMG_W_RESET;
            image_height_reg <= pnmp_pkg::IMG_H_RESET;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            left_pixel_reg   <= '0;
            upleft_pixel_reg <= '0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            byp_reg          <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (pnmp_pkg::cfg_index_t'(cfg_index))
                    pnmp_pkg::CFG_RESTORE_MODE: restore_mode_reg <= cfg_data[0];
                    pnmp_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[WW-1:0];
                    pnmp_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[HW-1:0];
                    default: begin
                    end
                endcase
            end
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            if (s1_fire) begin
                left_pixel_reg   <= store_val;
                upleft_pixel_reg <= up_pixel;
            end
            if (s_accept) begin
                byp_reg <= s1_fire && (s1_slot_reg == column_count_reg);
            end
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s1_adv) begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_pixel_reg    <= s_pixel_in;
            s1_slot_reg     <= column_count_reg;
            s1_col_zero_reg <= (column_count_reg == '0);
            s1_row_zero_reg <= (row_count_reg == '0);
            s1_last_reg     <= last_col && last_row;
            byp_data_reg    <= store_val;
        end
        if (s1_fire) begin
            out_pixel_reg <= res;
            out_last_reg  <= s1_last_reg;
        end
    end

    // line store: write on retire, registered read on accept
    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            row_store[s1_slot_reg] <= store_val;
        end
        if (s_accept) begin
            rd_data_reg <= row_store[column_count_reg];
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_pixel_out  = out_pixel_reg;
    assign m_frame_last = out_last_reg;

endmodule

`default_nettype wire
